// ----- rtl/core/ttu_pkg.sv -----
`default_nettype none

package ttu_pkg;

  // word width of the converted number
  localparam int WORD_BITS = 64;
  localparam int RADIX_BITS = 6;
  localparam int PROD_BITS = WORD_BITS + RADIX_BITS;

  // radix after reset
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_OCT = 6'd8;
  localparam logic [RADIX_BITS-1:0] RADIX_DEC = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_HEX = 6'd16;
  localparam logic [RADIX_BITS-1:0] RADIX_AUTO = 6'd0;

  // parse phase codes
  localparam logic [2:0] PH_DONE = 3'd0;
  localparam logic [2:0] PH_BLANK = 3'd1;
  localparam logic [2:0] PH_SIGNED = 3'd2;
  localparam logic [2:0] PH_ZERO = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  // character codes
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] UPPER_BIAS = 8'h37;  // 'A' - 10
  localparam logic [7:0] LOWER_BIAS = 8'h57;  // 'a' - 10

  // input word
  typedef struct packed {
    logic [7:0] char_code;
    logic       start_req;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [63:0] value;
    logic        overflowed;
  } out_word_t;

  // parse state carried from byte to byte
  typedef struct packed {
    logic [2:0]            phase;
    logic [WORD_BITS-1:0]  acc;
    logic                  negative;
    logic                  ovf;
    logic [RADIX_BITS-1:0] radix;
  } parse_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/ttu_step.sv -----
`default_nettype none

module ttu_step (
  input  wire ttu_pkg::parse_state_t            state_cur,
  input  wire ttu_pkg::in_word_t                item,
  input  wire logic [ttu_pkg::RADIX_BITS-1:0]   cfg_radix_val,
  output ttu_pkg::parse_state_t                 state_nxt,
  output logic                                  emit,
  output ttu_pkg::out_word_t                    result
);

  ttu_pkg::parse_state_t s;
  logic [7:0] c;
  logic [7:0] diff;
  logic [ttu_pkg::RADIX_BITS-1:0] dval;
  logic is_alnum;
  logic take;
  logic [ttu_pkg::RADIX_BITS-1:0] eb;
  logic [ttu_pkg::PROD_BITS-1:0] prod;
  logic ovf_new;
  logic [ttu_pkg::WORD_BITS-1:0] val_out;

  assign c = item.char_code;

  // digit value of the byte
  always_comb begin
    diff = 8'd0;
    is_alnum = 1'b0;
    if (c >= ttu_pkg::CH_ZERO && c <= ttu_pkg::CH_NINE) begin
      diff = c - ttu_pkg::CH_ZERO;
      is_alnum = 1'b1;
    end else if (c >= ttu_pkg::CH_LOWER_A && c <= ttu_pkg::CH_LOWER_Z) begin
      diff = c - ttu_pkg::LOWER_BIAS;
      is_alnum = 1'b1;
    end else if (c >= ttu_pkg::CH_UPPER_A && c <= ttu_pkg::CH_UPPER_Z) begin
      diff = c - ttu_pkg::UPPER_BIAS;
      is_alnum = 1'b1;
    end
    dval = diff[ttu_pkg::RADIX_BITS-1:0];
  end

  // phase handling, decides whether the byte goes to the digit path
  always_comb begin
    s = state_cur;
    if (item.start_req) begin
      s.phase = ttu_pkg::PH_BLANK;
      s.acc = '0;
      s.negative = 1'b0;
      s.ovf = 1'b0;
      s.radix = cfg_radix_val;
    end
    state_nxt = s;
    take = 1'b0;
    eb = s.radix;
    unique case (s.phase)
      ttu_pkg::PH_BLANK, ttu_pkg::PH_SIGNED: begin
        if (s.phase == ttu_pkg::PH_BLANK &&
            (c == ttu_pkg::CH_SPACE || c == ttu_pkg::CH_TAB)) begin
          state_nxt.phase = ttu_pkg::PH_BLANK;
        end else if (s.phase == ttu_pkg::PH_BLANK && c == ttu_pkg::CH_MINUS) begin
          state_nxt.negative = 1'b1;
          state_nxt.phase = ttu_pkg::PH_SIGNED;
        end else if (s.phase == ttu_pkg::PH_BLANK && c == ttu_pkg::CH_PLUS) begin
          state_nxt.phase = ttu_pkg::PH_SIGNED;
        end else if ((s.radix == ttu_pkg::RADIX_AUTO || s.radix == ttu_pkg::RADIX_HEX) &&
                     c == ttu_pkg::CH_ZERO) begin
          state_nxt.phase = ttu_pkg::PH_ZERO;
        end else begin
          take = 1'b1;
          if (s.radix == ttu_pkg::RADIX_AUTO) begin
            eb = ttu_pkg::RADIX_DEC;
          end
        end
      end
      ttu_pkg::PH_ZERO: begin
        // accumulator is still zero here, the leading zero adds nothing
        if (c == ttu_pkg::CH_LOWER_X || c == ttu_pkg::CH_UPPER_X) begin
          state_nxt.radix = ttu_pkg::RADIX_HEX;
          state_nxt.phase = ttu_pkg::PH_DIGITS;
        end else begin
          take = 1'b1;
          if (s.radix == ttu_pkg::RADIX_AUTO) begin
            eb = ttu_pkg::RADIX_OCT;
          end
        end
      end
      ttu_pkg::PH_DIGITS: begin
        take = 1'b1;
        if (s.radix == ttu_pkg::RADIX_AUTO) begin
          eb = ttu_pkg::RADIX_DEC;
        end
      end
      default: begin
        state_nxt.phase = ttu_pkg::PH_DONE;
      end
    endcase

    // digit path: accumulate or end the number
    emit = 1'b0;
    if (take) begin
      state_nxt.radix = eb;
      if (is_alnum && dval < eb) begin
        state_nxt.phase = ttu_pkg::PH_DIGITS;
        state_nxt.ovf = ovf_new;
        if (!ovf_new) begin
          state_nxt.acc = prod[ttu_pkg::WORD_BITS-1:0];
        end
      end else begin
        state_nxt.phase = ttu_pkg::PH_DONE;
        emit = 1'b1;
      end
    end
  end

  // multiply-accumulate, overflow when the product leaves the word
  assign prod = ttu_pkg::PROD_BITS'(s.acc) * ttu_pkg::PROD_BITS'(eb) +
                ttu_pkg::PROD_BITS'(dval);
  assign ovf_new = s.ovf ||
                   (prod[ttu_pkg::PROD_BITS-1:ttu_pkg::WORD_BITS] != '0);

  // result value
  always_comb begin
    if (s.ovf) begin
      val_out = '1;
    end else if (s.negative) begin
      val_out = ttu_pkg::WORD_BITS'(0) - s.acc;
    end else begin
      val_out = s.acc;
    end
    result.value = 64'(val_out);
    result.overflowed = s.ovf;
  end

endmodule

`default_nettype wire

// ----- rtl/core/text_to_unsigned_parser.sv -----
// Streaming text to unsigned integer converter, one byte per word.
// Input channel (in_valid/in_ready/in_word): a byte and a start flag; the
// start flag opens a new string and samples the radix register.
// Result channel (out_valid/out_ready/out_word): at most one word per string, given
// at the first byte that is not a digit of the base: value and overflow flag.
// Configuration channel (cfg_valid/cfg_ready/cfg_radix): radix, 0 = auto
// octal/decimal/hex; cfg_ready is always high, write only while idle.
// An accepted byte is held in the input register while it is parsed; its
// result is written into the result register when the byte advances.
// Throughput: one byte per cycle while no pending result stalls a byte that
// would produce one, set by the single multiply-accumulate between the input
// register and the result register.
// Reset: radix returns to 10, the parser ignores bytes until a start flag,
// and both registers are empty.
// Stall: a pending result holds the output register; bytes that produce no
// result keep flowing, and a byte that would produce one waits in the input
// register, which then drops in_ready.
`default_nettype none

module text_to_unsigned_parser (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire ttu_pkg::in_word_t               in_word,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output ttu_pkg::out_word_t                   out_word,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ttu_pkg::RADIX_BITS-1:0]  cfg_radix
);

  logic                            in_valid_r;
  ttu_pkg::in_word_t               in_word_r;
  logic [ttu_pkg::RADIX_BITS-1:0]  radix_r;
  ttu_pkg::parse_state_t           state_r;
  ttu_pkg::parse_state_t           state_nxt;
  logic                            out_valid_r;
  ttu_pkg::out_word_t              out_word_r;
  ttu_pkg::out_word_t              result;
  logic                            emit;
  logic                            advance;

  // per-byte parse logic
  ttu_step u_step (
    .state_cur     (state_r),
    .item          (in_word_r),
    .cfg_radix_val (radix_r),
    .state_nxt     (state_nxt),
    .emit          (emit),
    .result        (result)
  );

  // handshake control
  assign advance = in_valid_r && (!emit || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

  // radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= ttu_pkg::RADIX_RESET;
    end else if (cfg_valid) begin
      radix_r <= cfg_radix;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_word_r <= in_word;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase <= ttu_pkg::PH_DONE;
      state_r.acc <= '0;
      state_r.negative <= 1'b0;
      state_r.ovf <= 1'b0;
      state_r.radix <= ttu_pkg::RADIX_AUTO;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_word_r <= result;
    end
  end

endmodule

`default_nettype wire

// ----- tb/text_to_unsigned_parser_test.sv -----
`timescale 1ns / 1ps

module text_to_unsigned_parser_test;
  import ttu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 72;
  localparam logic [WORD_BITS-1:0] WORD_MASK = '1;

  typedef enum logic [0:0] {ROW_BYTE, ROW_RADIX} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [7:0]            ch;
    bit                    st;
    logic [RADIX_BITS-1:0] radix;
    bit                    given;
    logic [63:0]           value;
    bit                    ovf;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RADIX_BITS-1:0] cfg_radix = RADIX_RESET;

  // parser model state
  logic [RADIX_BITS-1:0] radix_cfg;
  logic [2:0]            ph;
  logic [WORD_BITS-1:0]  acc;
  bit                    neg;
  bit                    ovf_seen;
  logic [RADIX_BITS-1:0] act_radix;

  out_word_t pending_results[$];
  in_word_t  text_q[$];
  stim_row_t directed_rows[$];
  out_word_t expected_word;
  int        fail_count = 0;
  int        cycle_count = 0;
  bit        no_idle = 1'b0;

  text_to_unsigned_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_radix (cfg_radix)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // digit value of a byte, 64 when it is neither digit nor letter
  function automatic logic [6:0] char_digit(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 7'(c - CH_ZERO);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return 7'(c - LOWER_BIAS);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return 7'(c - UPPER_BIAS);
    return 7'd64;
  endfunction

  // multiply-accumulate with saturation on overflow
  task automatic push_digit(logic [6:0] d);
    logic [WORD_BITS-1:0] base, cut, lim;
    base = (act_radix == RADIX_AUTO) ? 64'd10 : 64'(act_radix);
    cut = WORD_MASK / base;
    lim = WORD_MASK % base;
    if (ovf_seen || acc > cut || (acc == cut && 64'(d) > lim))
      ovf_seen = 1'b1;
    else
      acc = acc * base + 64'(d);
  endtask

  // digit phase: consume a digit or close the number
  task automatic digit_or_end(logic [7:0] c, output bit emitted, output out_word_t r);
    logic [6:0] d;
    logic [6:0] base;
    d = char_digit(c);
    base = (act_radix == RADIX_AUTO) ? 7'd10 : 7'(act_radix);
    r = '0;
    emitted = 1'b0;
    if (d < base) begin
      push_digit(d);
      ph = PH_DIGITS;
    end else begin
      emitted = 1'b1;
      if (ovf_seen) begin
        r.value = WORD_MASK;
        r.overflowed = 1'b1;
      end else begin
        r.value = neg ? -acc : acc;
        r.overflowed = 1'b0;
      end
      ph = PH_DONE;
    end
  endtask

  // first byte after blanks and sign
  task automatic first_char(logic [7:0] c, output bit emitted, output out_word_t r);
    r = '0;
    emitted = 1'b0;
    if ((act_radix == RADIX_AUTO || act_radix == RADIX_HEX) && c == CH_ZERO) begin
      ph = PH_ZERO;
    end else begin
      if (act_radix == RADIX_AUTO) act_radix = RADIX_DEC;
      digit_or_end(c, emitted, r);
    end
  endtask

  // expected result of one accepted input word
  task automatic parse_byte(in_word_t w, output bit emitted, output out_word_t r);
    logic [7:0] c;
    c = w.char_code;
    r = '0;
    emitted = 1'b0;
    if (w.start_req) begin
      ph = PH_BLANK;
      acc = '0;
      neg = 1'b0;
      ovf_seen = 1'b0;
      act_radix = radix_cfg;
    end
    case (ph)
      PH_BLANK: begin
        if (c == CH_SPACE || c == CH_TAB) begin
        end else if (c == CH_MINUS) begin
          neg = 1'b1;
          ph = PH_SIGNED;
        end else if (c == CH_PLUS) begin
          ph = PH_SIGNED;
        end else begin
          first_char(c, emitted, r);
        end
      end
      PH_SIGNED: begin
        first_char(c, emitted, r);
      end
      PH_ZERO: begin
        if (c == CH_LOWER_X || c == CH_UPPER_X) begin
          act_radix = RADIX_HEX;
          ph = PH_DIGITS;
        end else begin
          if (act_radix == RADIX_AUTO) act_radix = RADIX_OCT;
          push_digit(7'd0);
          digit_or_end(c, emitted, r);
        end
      end
      PH_DIGITS: begin
        digit_or_end(c, emitted, r);
      end
      default: begin
      end
    endcase
  endtask

  // send one input word after a random gap, predict at acceptance
  task automatic send_word(in_word_t w, output bit emitted, output out_word_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    parse_byte(w, emitted, r);
  endtask

  // radix write once the parser has drained
  task automatic write_radix(logic [RADIX_BITS-1:0] rdx);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_radix <= rdx;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radix_cfg = rdx;
  endtask

  function automatic logic [7:0] digit_char(logic [6:0] d);
    if (d < 7'd10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(d) - 8'd10;
  endfunction

  // append one random string, mostly well formed, to the text queue
  task automatic compose_string(logic [RADIX_BITS-1:0] rdx);
    in_word_t   w;
    int         b, n, mode, k;
    logic [7:0] chs[$];
    if ($urandom_range(0, 99) < 12) begin
      // noise: random bytes, random start flags
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) begin
        w.char_code = 8'($urandom);
        w.start_req = 1'($urandom_range(0, 1));
        text_q.push_back(w);
      end
    end else begin
      b = (rdx == RADIX_AUTO) ? 10 : ((rdx > 6'd36) ? 36 : int'(rdx));
      n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2);
      for (k = 0; k < n; k++) chs.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      case ($urandom_range(0, 2))
        1: chs.push_back(CH_PLUS);
        2: chs.push_back(CH_MINUS);
        default: begin
        end
      endcase
      if ((rdx == RADIX_AUTO || rdx == RADIX_HEX) && $urandom_range(0, 99) < 30) begin
        chs.push_back(CH_ZERO);
        chs.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
        b = 16;
      end else if (rdx == RADIX_AUTO && $urandom_range(0, 99) < 25) begin
        chs.push_back(CH_ZERO);
        b = 8;
      end
      mode = $urandom_range(0, 99);
      n = (mode < 20) ? $urandom_range(10, 24) : $urandom_range(0, 8);
      for (k = 0; k < n; k++)
        chs.push_back(digit_char(7'((mode < 8) ? b - 1 : $urandom_range(0, b - 1))));
      // terminator, left out now and then so the next start cuts in
      if ($urandom_range(0, 99) < 90) begin
        case ($urandom_range(0, 2))
          0: chs.push_back(8'h00);
          1: chs.push_back(CH_SPACE);
          default: chs.push_back(8'($urandom));
        endcase
      end
      if (chs.size() == 0) chs.push_back(8'($urandom));
      foreach (chs[i]) begin
        w.char_code = chs[i];
        w.start_req = (i == 0);
        text_q.push_back(w);
      end
    end
  endtask

  task automatic add_byte(logic [7:0] ch, bit st);
    directed_rows.push_back('{ROW_BYTE, ch, st, RADIX_RESET, 1'b0, 64'd0, 1'b0});
  endtask

  task automatic add_given(logic [7:0] ch, bit st, logic [63:0] value, bit ovf);
    directed_rows.push_back('{ROW_BYTE, ch, st, RADIX_RESET, 1'b1, value, ovf});
  endtask

  task automatic add_radix(logic [RADIX_BITS-1:0] rdx);
    directed_rows.push_back('{ROW_RADIX, 8'h00, 1'b0, rdx, 1'b0, 64'd0, 1'b0});
  endtask

  // result receiver with random stalls
  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: value %h overflowed %b",
               out_word.value, out_word.overflowed);
        fail_count++;
      end else begin
        expected_word = pending_results.pop_front();
        if (out_word.value !== expected_word.value) begin
          $error("value: expected %h, actual %h", expected_word.value, out_word.value);
          fail_count++;
        end
        if (out_word.overflowed !== expected_word.overflowed) begin
          $error("overflowed: expected %b, actual %b",
                 expected_word.overflowed, out_word.overflowed);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [RADIX_BITS-1:0] phase_radix[12];
    out_word_t r;
    bit        emitted;
    in_word_t  w;
    int        sent;
    int        total;

    radix_cfg = RADIX_RESET;
    ph = PH_DONE;
    acc = '0;
    neg = 1'b0;
    ovf_seen = 1'b0;
    act_radix = RADIX_AUTO;

    // directed strings
    add_byte(CH_UPPER_A, 1'b0);               // ignored before any start
    add_byte(CH_TAB, 1'b1);
    add_byte(CH_MINUS, 1'b0);
    add_byte(8'h37, 1'b0);
    add_byte(8'hFF, 1'b0);                    // ends "-7"
    add_byte(CH_PLUS, 1'b1);
    add_given(CH_LOWER_Z, 1'b0, 64'd0, 1'b0); // no digits
    add_byte(8'h33, 1'b1);
    add_byte(8'h34, 1'b1);                    // restart drops the old string
    add_given(8'h00, 1'b0, 64'd4, 1'b0);
    add_radix(RADIX_AUTO);
    add_byte(CH_ZERO, 1'b1);
    add_byte(CH_UPPER_X, 1'b0);
    add_given(8'h67, 1'b0, 64'd0, 1'b0);      // empty hex prefix
    add_byte(CH_ZERO, 1'b1);
    add_byte(8'h37, 1'b0);
    add_given(8'h38, 1'b0, 64'd7, 1'b0);      // leading zero picks octal
    add_radix(6'd63);
    add_byte(CH_MINUS, 1'b1);
    repeat (11) add_byte(CH_LOWER_Z, 1'b0);
    add_given(CH_SPACE, 1'b0, WORD_MASK, 1'b1); // saturated, sign ignored

    phase_radix = '{6'd1, 6'd63, RADIX_AUTO, RADIX_HEX, 6'd2, 6'd36, 6'd37, RADIX_OCT,
                    RADIX_DEC, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                    RADIX_AUTO};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_RADIX) begin
        write_radix(directed_rows[i].radix);
      end else begin
        w.char_code = directed_rows[i].ch;
        w.start_req = directed_rows[i].st;
        send_word(w, emitted, r);
        if (directed_rows[i].given)
          pending_results.push_back('{value: directed_rows[i].value,
                                      overflowed: directed_rows[i].ovf});
        else if (emitted)
          pending_results.push_back(r);
      end
    end

    // random strings, radix rewritten between phases; leftover text carries over
    total = 0;
    foreach (phase_radix[p]) begin
      write_radix(phase_radix[p]);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        if (text_q.size() == 0) compose_string(radix_cfg);
        if (total % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        w = text_q.pop_front();
        send_word(w, emitted, r);
        if (emitted) pending_results.push_back(r);
        sent++;
        total++;
      end
    end

    // drain
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- text_to_unsigned_parser.f -----
rtl/core/ttu_pkg.sv
rtl/core/ttu_step.sv
rtl/core/text_to_unsigned_parser.sv
tb/text_to_unsigned_parser_test.sv
